// ===== hdl/tpid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpid_pkg
// Shared types, constants and lookup helpers of the tiled palette icon decoder.
// ----------------------------------------------------------------------------
package tpid_pkg;

	// palette geometry
	localparam int PALETTE_BANKS = 8;
	localparam int BANK_COLORS   = 16;
	localparam int STORE_DEPTH   = PALETTE_BANKS * BANK_COLORS;
	localparam int STORE_AW      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	// icon geometry
	localparam int ICON_SIDE = 32;
	localparam int SIDE_W    = $clog2(ICON_SIDE);

	// field widths
	localparam int ENTRY_W  = 7;
	localparam int COLOR_W  = 15;
	localparam int OFFSET_W = 9;
	localparam int BYTE_W   = 8;
	localparam int NIB_W    = 4;
	localparam int BANK_W   = 3;
	localparam int ADDR_W   = 10;
	localparam int ARGB_W   = 32;

	localparam logic [BANK_W-1:0] LAST_BANK  = BANK_W'(PALETTE_BANKS - 1);
	localparam logic [BANK_W:0]   BANK_COUNT = (BANK_W + 1)'(PALETTE_BANKS);

	// configuration register indexes
	localparam logic [1:0] REG_PALETTE_BANK    = 2'd0;
	localparam logic [1:0] REG_FLIP_HORIZONTAL = 2'd1;
	localparam logic [1:0] REG_FLIP_VERTICAL   = 2'd2;

	// item actions
	localparam logic ACTION_WRITE  = 1'b0;
	localparam logic ACTION_DECODE = 1'b1;

	// 5-bit channel to 8-bit, c*255/31 rounded down
	localparam logic [7:0] EXPAND5_LUT [0:31] = '{
		8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
		8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
		8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
		8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
	};

	typedef struct packed {
		logic                action;
		logic [ENTRY_W-1:0]  palette_entry;
		logic [COLOR_W-1:0]  palette_color;
		logic [OFFSET_W-1:0] byte_offset;
		logic [BYTE_W-1:0]   data_byte;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] first_address;
		logic [ARGB_W-1:0] first_color;
		logic [ADDR_W-1:0] second_address;
		logic [ARGB_W-1:0] second_color;
	} out_item_t;

	// common control sent to every lane
	typedef struct packed {
		logic                rd_en;
		logic                wr_en;
		logic [STORE_AW-1:0] wr_addr;
		logic [COLOR_W-1:0]  wr_data;
		logic [BANK_W-1:0]   bank;
		logic                flip_h;
		logic                flip_v;
		logic [OFFSET_W-1:0] offset;
	} lane_ctl_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [ARGB_W-1:0] color;
	} lane_res_t;

	// tiled byte position to linear pixel address, with mirroring
	function automatic logic [ADDR_W-1:0] pixel_address(
		input logic [OFFSET_W-1:0] offset,
		input logic                odd,
		input logic                flip_h,
		input logic                flip_v
	);
		logic [SIDE_W-1:0] row;
		logic [SIDE_W-1:0] col;
		row = {offset[8:7], offset[4:2]};
		col = {offset[6:5], offset[1:0], odd};
		if (flip_h) begin
			col = ~col;
		end
		if (flip_v) begin
			row = ~row;
		end
		return {row, col};
	endfunction

	function automatic logic [ARGB_W-1:0] bgr_to_argb(
		input logic [COLOR_W-1:0] bgr,
		input logic               opaque
	);
		logic [7:0] alpha;
		alpha = opaque ? 8'hFF : 8'h00;
		return {alpha, EXPAND5_LUT[bgr[4:0]], EXPAND5_LUT[bgr[9:5]],
			EXPAND5_LUT[bgr[14:10]]};
	endfunction

endpackage

// ===== hdl/tpid_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpid_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tpid_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/tpid_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpid_lane
// One pixel lane: private palette copy, address mapping and color expansion.
// ----------------------------------------------------------------------------
module tpid_lane (
	input  logic                        clk,
	input  tpid_pkg::lane_ctl_t         ctl,
	input  logic [tpid_pkg::NIB_W-1:0]  nibble,
	input  logic                        odd,
	output tpid_pkg::lane_res_t         res
);

	logic [tpid_pkg::STORE_AW-1:0] rd_addr;
	logic [tpid_pkg::COLOR_W-1:0]  bgr_s1;
	logic [tpid_pkg::ADDR_W-1:0]   address_s1;
	logic                          opaque_s1;

	assign rd_addr = tpid_pkg::STORE_AW'({ctl.bank, nibble});

	tpid_ram #(
		.WIDTH (tpid_pkg::COLOR_W),
		.DEPTH (tpid_pkg::STORE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (ctl.wr_en),
		.waddr (ctl.wr_addr),
		.wdata (ctl.wr_data),
		.re    (ctl.rd_en),
		.raddr (rd_addr),
		.rdata (bgr_s1)
	);

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			address_s1 <= tpid_pkg::pixel_address(ctl.offset, odd, ctl.flip_h, ctl.flip_v);
			opaque_s1  <= (nibble != '0);
		end
	end

	assign res.address = address_s1;
	assign res.color   = tpid_pkg::bgr_to_argb(bgr_s1, opaque_s1);

endmodule

// ===== hdl/tpid_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpid_merge
// Joins the two lane results into one output item and holds it under stall.
// ----------------------------------------------------------------------------
module tpid_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  tpid_pkg::lane_res_t low_res,
	input  tpid_pkg::lane_res_t high_res,
	input  logic                out_stall,
	output logic                out_valid,
	output tpid_pkg::out_item_t out_data,
	output logic                load_s2
);

	logic valid_s2;

	assign load_s2 = !valid_s2 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			out_data.first_address  <= low_res.address;
			out_data.first_color    <= low_res.color;
			out_data.second_address <= high_res.address;
			out_data.second_color   <= high_res.color;
		end
	end

	assign out_valid = valid_s2;

endmodule

// ===== hdl/tiled_palette_icon_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_palette_icon_decoder
// Turns 4bpp tiled icon bytes into pairs of ARGB8888 pixels with linear
// addresses, using banked BGR555 palettes loaded through the input stream.
// ----------------------------------------------------------------------------
//
//  channel | handshake                | payload              | direction
//  --------+--------------------------+----------------------+----------
//  in      | in_valid / in_stall      | in_data  (in_item_t) | into block
//  out     | out_valid / out_stall    | out_data (out_item_t)| out of block
//  cfg     | cfg_we                   | cfg_index, cfg_data  | into block
//
//  one item per cycle while in_stall is low; a decode result passes the palette
//  RAM read register in each lane and then the merge register, where it is
//  offered; palette writes land in both lane RAMs, no result
//  reset clears the pipeline valids and the config registers; the palette
//  is not cleared, so the block takes items right after reset
//  the input stalls only while a held result and the read stage are both full
//
module tiled_palette_icon_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tpid_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output tpid_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [tpid_pkg::BANK_W-1:0] cfg_data
);

	// configuration registers
	logic [tpid_pkg::BANK_W-1:0] bank_q;
	logic                        flip_h_q;
	logic                        flip_v_q;

	// read stage state
	logic valid_s1;
	logic load_s1;
	logic load_s2;
	logic in_xfer;
	logic is_decode;
	logic bank_ok;

	tpid_pkg::lane_ctl_t ctl;
	tpid_pkg::lane_res_t low_res;
	tpid_pkg::lane_res_t high_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q   <= '0;
			flip_h_q <= 1'b0;
			flip_v_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tpid_pkg::REG_PALETTE_BANK:    bank_q   <= cfg_data;
				tpid_pkg::REG_FLIP_HORIZONTAL: flip_h_q <= cfg_data[0];
				tpid_pkg::REG_FLIP_VERTICAL:   flip_v_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// read stage frees when empty or when its item moves to the merge register
	assign load_s1   = !valid_s1 || load_s2;
	assign in_stall  = !load_s1;
	assign in_xfer   = in_valid && load_s1;
	assign is_decode = (in_data.action == tpid_pkg::ACTION_DECODE);

	// writes to banks past the last one are dropped
	assign bank_ok = {1'b0, in_data.palette_entry[6:4]} < tpid_pkg::BANK_COUNT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_xfer && is_decode;
		end
	end

	always_comb begin
		ctl.rd_en   = load_s1;
		ctl.wr_en   = in_xfer && !is_decode && bank_ok;
		ctl.wr_addr = tpid_pkg::STORE_AW'(in_data.palette_entry);
		ctl.wr_data = in_data.palette_color;
		// bank beyond the stored ones falls back to the last bank
		ctl.bank    = (bank_q > tpid_pkg::LAST_BANK) ? tpid_pkg::LAST_BANK : bank_q;
		ctl.flip_h  = flip_h_q;
		ctl.flip_v  = flip_v_q;
		ctl.offset  = in_data.byte_offset;
	end

	// low nibble lane, earlier pixel in tiled order
	tpid_lane u_lane_low (
		.clk    (clk),
		.ctl    (ctl),
		.nibble (in_data.data_byte[3:0]),
		.odd    (1'b0),
		.res    (low_res)
	);

	// high nibble lane, later pixel in tiled order
	tpid_lane u_lane_high (
		.clk    (clk),
		.ctl    (ctl),
		.nibble (in_data.data_byte[7:4]),
		.odd    (1'b1),
		.res    (high_res)
	);

	tpid_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.low_res   (low_res),
		.high_res  (high_res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.load_s2   (load_s2)
	);

endmodule

// ===== hdl/tpid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpid_checker
// Port-level checks of the tiled palette icon decoder, bound to the top.
// ----------------------------------------------------------------------------
module tpid_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input tpid_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_stall,
	input tpid_pkg::out_item_t out_data,
	input logic                cfg_we,
	input logic [1:0]          cfg_index,
	input logic [tpid_pkg::BANK_W-1:0] cfg_data
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// and keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("result changed while stalled");

	// every decode transfer is followed by out_valid once the read and merge registers are passed
	a_decode_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.action == tpid_pkg::ACTION_DECODE
		|=> ##1 out_valid)
		else $error("decode result missing");

	// input never backs up while no result waits
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// the two pixels of a byte are horizontal neighbors
	a_pixel_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.first_address ^ out_data.second_address) == 10'd1))
		else $error("pixel pair addresses not adjacent");

endmodule

bind tiled_palette_icon_decoder tpid_checker u_tpid_checker (.*);

// ===== test/tb_tiled_palette_icon_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tiled_palette_icon_decoder
// Self-checking bench for the tiled palette icon decoder. It fills the palette
// banks, runs directed decodes at the corners of the icon and of the color
// space, sweeps bank and mirror settings, then streams random palette writes
// and decodes. A local model predicts every pixel pair and a checker compares
// each output transfer field by field. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_tiled_palette_icon_decoder;
	import tpid_pkg::*;

	localparam int IN_BITS = $bits(in_item_t);

	// clock, reset and block ports
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	in_item_t            in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_item_t           out_data;
	logic                cfg_we = 1'b0;
	logic [1:0]          cfg_index = REG_PALETTE_BANK;
	logic [BANK_W-1:0]   cfg_data = '0;

	// local copy of the decoder state
	logic [COLOR_W-1:0]  palette_copy [0:STORE_DEPTH-1];
	logic [BANK_W-1:0]   bank_sel = '0;
	logic                mirror_cols = 1'b0;
	logic                mirror_rows = 1'b0;

	// pixel pairs predicted but not yet seen on the output
	out_item_t           pixel_queue [$];
	int                  mismatch_count = 0;

	// pressure knobs, switched per phase
	bit                  in_gaps_on = 1'b0;
	bit                  stall_on = 1'b0;
	int                  stall_hold = 0;
	int                  stall_roll;

	tiled_palette_icon_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// pixel prediction
	// ------------------------------------------------------------------

	// 5-bit channel scaled to 8 bits, rounding down
	function automatic logic [7:0] widen_channel(input logic [4:0] c);
		return 8'((int'(c) * 255) / 31);
	endfunction

	// argb of one 4-bit palette index in the selected bank
	function automatic logic [ARGB_W-1:0] shade_of(input logic [NIB_W-1:0] idx);
		logic [BANK_W-1:0]  bank;
		logic [COLOR_W-1:0] bgr;
		logic [7:0]         alpha;
		bank = bank_sel;
		// a bank past the last one falls back to the last one
		if (int'(bank) >= PALETTE_BANKS) begin
			bank = BANK_W'(PALETTE_BANKS - 1);
		end
		bgr = palette_copy[{bank, idx}];
		// index zero is transparent but keeps its color channels
		alpha = (idx != '0) ? 8'hFF : 8'h00;
		return {alpha, widen_channel(bgr[4:0]), widen_channel(bgr[9:5]),
			widen_channel(bgr[14:10])};
	endfunction

	// pixel number in tiled order to row*32+column after mirroring
	function automatic logic [ADDR_W-1:0] linear_address(input logic [9:0] pix);
		int row;
		int col;
		row = int'(pix[9:8]) * 8 + int'(pix[5:3]);
		col = int'(pix[7:6]) * 8 + int'(pix[2:0]);
		if (mirror_cols) begin
			col = (ICON_SIDE - 1) - col;
		end
		if (mirror_rows) begin
			row = (ICON_SIDE - 1) - row;
		end
		return ADDR_W'(row * ICON_SIDE + col);
	endfunction

	// update the local state for one accepted item
	task automatic apply_item(input in_item_t item);
		out_item_t  pair;
		logic [9:0] pix;
		if (item.action == ACTION_WRITE) begin
			if (int'(item.palette_entry[6:4]) < PALETTE_BANKS) begin
				palette_copy[item.palette_entry] = item.palette_color;
			end
		end else begin
			pix = {item.byte_offset, 1'b0};
			pair.first_address  = linear_address(pix);
			pair.first_color    = shade_of(item.data_byte[3:0]);
			pair.second_address = linear_address(pix | 10'd1);
			pair.second_color   = shade_of(item.data_byte[7:4]);
			pixel_queue = {pixel_queue, pair};
		end
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// palette write, bitmap fields carry noise
	function automatic in_item_t make_write(input logic [ENTRY_W-1:0] entry,
		input logic [COLOR_W-1:0] color);
		in_item_t item;
		item = in_item_t'(IN_BITS'({$urandom, $urandom}));
		item.action        = ACTION_WRITE;
		item.palette_entry = entry;
		item.palette_color = color;
		return item;
	endfunction

	// decode of one bitmap byte, palette fields carry noise
	function automatic in_item_t make_decode(input logic [OFFSET_W-1:0] offset,
		input logic [BYTE_W-1:0] data);
		in_item_t item;
		item = in_item_t'(IN_BITS'({$urandom, $urandom}));
		item.action      = ACTION_DECODE;
		item.byte_offset = offset;
		item.data_byte   = data;
		return item;
	endfunction

	// one input transfer, called and returning at a falling edge
	task automatic send_item(input in_item_t item);
		int gap;
		int roll;
		in_data  = item;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		apply_item(item);
		@(negedge clk);
		gap = 0;
		if (in_gaps_on) begin
			roll = $urandom_range(0, 99);
			if (roll >= 90) begin
				gap = $urandom_range(4, 20);
			end else if (roll >= 60) begin
				gap = $urandom_range(1, 3);
			end
		end
		if (gap > 0) begin
			// idle bus carries garbage
			in_valid = 1'b0;
			repeat (gap) begin
				in_data = in_item_t'(IN_BITS'({$urandom, $urandom}));
				@(negedge clk);
			end
		end
	endtask

	// stop sending, wait for every result, then let the palette write settle
	task automatic drain_pipeline();
		in_valid = 1'b0;
		while (pixel_queue.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// register write, only while the block is idle
	task automatic write_reg(input logic [1:0] idx, input logic [BANK_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_PALETTE_BANK: begin
				bank_sel = val;
			end
			REG_FLIP_HORIZONTAL: begin
				mirror_cols = val[0];
			end
			REG_FLIP_VERTICAL: begin
				mirror_rows = val[0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic set_config(input logic [BANK_W-1:0] bank, input logic fh,
		input logic fv);
		drain_pipeline();
		write_reg(REG_PALETTE_BANK, bank);
		write_reg(REG_FLIP_HORIZONTAL, BANK_W'(fh));
		write_reg(REG_FLIP_VERTICAL, BANK_W'(fv));
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// every entry gets a color before any decode can read it
	task automatic test_palette_fill();
		for (int e = 0; e < STORE_DEPTH; e++) begin
			send_item(make_write(ENTRY_W'(e), COLOR_W'($urandom)));
		end
	endtask

	// corners of the icon, of the color space and of the nibbles
	task automatic test_directed();
		set_config(3'd0, 1'b0, 1'b0);
		send_item(make_write(7'd0, 15'h7FFF));
		send_item(make_write(7'd1, 15'h0000));
		send_item(make_write(7'd2, 15'h001F));
		send_item(make_write(7'd3, 15'h03E0));
		send_item(make_write(7'd4, 15'h7C00));
		send_item(make_write(7'd15, 15'h7FFF));
		// index zero keeps full color channels with clear alpha
		send_item(make_decode(9'd0, 8'h10));
		send_item(make_decode(9'd511, 8'hF0));
		send_item(make_decode(9'd0, 8'h00));
		send_item(make_decode(9'd511, 8'hFF));
		send_item(make_decode(9'h155, 8'h32));
		send_item(make_decode(9'h0AA, 8'h4F));
		send_item(make_decode(9'h1AA, 8'h0F));
		// write then read the same entry back to back
		send_item(make_write(7'd5, 15'h5555));
		send_item(make_decode(9'h03F, 8'h55));
		send_item(make_write(7'd5, 15'h2AAA));
		send_item(make_decode(9'h1C0, 8'h5A));
		// last bank, last entry
		set_config(3'd7, 1'b1, 1'b1);
		send_item(make_write(7'd127, 15'h7FFF));
		send_item(make_write(7'd112, 15'h0000));
		send_item(make_decode(9'd0, 8'h0F));
		send_item(make_decode(9'd511, 8'hF0));
	endtask

	// every mirror combination against the end banks and a random one
	task automatic test_flip_and_bank();
		logic [BANK_W-1:0] bank;
		for (int b = 0; b < 3; b++) begin
			bank = (b == 0) ? 3'd0 : (b == 1) ? 3'd7 : BANK_W'($urandom);
			for (int f = 0; f < 4; f++) begin
				set_config(bank, f[0], f[1]);
				send_item(make_decode(9'd0, BYTE_W'($urandom)));
				send_item(make_decode(9'd511, BYTE_W'($urandom)));
				for (int k = 0; k < 6; k++) begin
					send_item(make_decode(OFFSET_W'($urandom), BYTE_W'($urandom)));
				end
			end
		end
	endtask

	// mixed writes and decodes in phases with fresh settings and pressure
	task automatic test_random_stream();
		for (int phase = 0; phase < 7; phase++) begin
			set_config(BANK_W'($urandom), 1'($urandom), 1'($urandom));
			// some phases run without any idling on either side
			in_gaps_on = ($urandom_range(0, 3) != 0);
			stall_on   = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < 80; k++) begin
				if ($urandom_range(0, 3) == 0) begin
					send_item(make_write(ENTRY_W'($urandom), COLOR_W'($urandom)));
				end else begin
					send_item(make_decode(OFFSET_W'($urandom), BYTE_W'($urandom)));
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// output side: stall pattern and checking
	// ------------------------------------------------------------------

	// mostly short stalls, now and then a long one
	always @(negedge clk) begin
		if (stall_hold > 0) begin
			stall_hold--;
		end else if (!stall_on) begin
			out_stall = 1'b0;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 65) begin
				out_stall  = 1'b0;
				stall_hold = $urandom_range(0, 3);
			end else if (stall_roll < 92) begin
				out_stall  = 1'b1;
				stall_hold = $urandom_range(0, 2);
			end else begin
				out_stall  = 1'b1;
				stall_hold = $urandom_range(3, 25);
			end
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	// each output transfer against the oldest prediction
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_queue.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: %h", out_data));
			end else begin
				want = pixel_queue.pop_front();
				if (out_data.first_address !== want.first_address) begin
					report_mismatch($sformatf("first_address got %h want %h",
						out_data.first_address, want.first_address));
				end
				if (out_data.first_color !== want.first_color) begin
					report_mismatch($sformatf("first_color got %h want %h",
						out_data.first_color, want.first_color));
				end
				if (out_data.second_address !== want.second_address) begin
					report_mismatch($sformatf("second_address got %h want %h",
						out_data.second_address, want.second_address));
				end
				if (out_data.second_color !== want.second_color) begin
					report_mismatch($sformatf("second_color got %h want %h",
						out_data.second_color, want.second_color));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		in_gaps_on = 1'b1;
		stall_on   = 1'b1;
		test_palette_fill();
		test_directed();
		test_flip_and_bank();
		test_random_stream();
		drain_pipeline();
		repeat (10) @(negedge clk);
		// anything left over is a lost result
		if (pixel_queue.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pixel_queue.size()));
		end
		if (mismatch_count == 0) begin
			$display("[tiled_palette_icon_decoder] OK");
		end else begin
			$display("[tiled_palette_icon_decoder] ERROR");
		end
		$finish;
	end

	// hard stop for a hung handshake
	initial begin
		#10_000_000;
		$display("[tiled_palette_icon_decoder] ERROR");
		$finish;
	end

endmodule

// ===== tiled_palette_icon_decoder.f =====
hdl/tpid_pkg.sv
hdl/tpid_ram.sv
hdl/tpid_lane.sv
hdl/tpid_merge.sv
hdl/tiled_palette_icon_decoder.sv
hdl/tpid_checker.sv
test/tb_tiled_palette_icon_decoder.sv
